// File: hw/rtl/hsv2rgb_pkg.sv
// Package for the HSV to RGB pixel converter: widths, reciprocal constants,
// hue sector type and the hue split function.
// No dependencies.
package hsv2rgb_pkg;

   // field widths
   localparam int HUE_W   = 9;
   localparam int CH_W    = 8;
   localparam int FRAC_W  = 6;
   localparam int PROD_W  = 14;   // s*f and s*(60-f), at most 15300
   localparam int PNUM_W  = 16;   // v*(255-s)
   localparam int QNUM_W  = 22;   // v*(15300-x)

   // angle and level constants
   localparam logic [HUE_W-1:0]  HUE_FULL   = 9'd360;
   localparam logic [HUE_W-1:0]  HUE_SECTOR = 9'd60;
   localparam logic [FRAC_W-1:0] FRAC_FULL  = 6'd60;
   localparam logic [CH_W-1:0]   CH_MAX     = 8'd255;
   localparam logic [PROD_W-1:0] QT_DEN     = 14'd15300;

   // floor(x/255) = (x*P_RECIP) >> P_SHIFT, exact for x < 2^16
   localparam int               P_RECIP_W = 17;
   localparam logic [16:0]      P_RECIP   = 17'd65794;
   localparam int               P_SHIFT   = 24;
   localparam int               PPROD_W   = PNUM_W + P_RECIP_W;

   // floor(x/15300) = (x*QT_RECIP) >> QT_SHIFT, exact for x < 2^22
   localparam int               QT_RECIP_W = 23;
   localparam logic [22:0]      QT_RECIP   = 23'd4491470;
   localparam int               QT_SHIFT   = 36;
   localparam int               QPROD_W    = QNUM_W + QT_RECIP_W;

   // sixty-degree hue sectors
   typedef enum logic [2:0] {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } sector_type;

   typedef struct packed {
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
   } hue_split_type;

   // Wrap the hue once into 0..359, then find its sector and the remainder
   // inside the sector with parallel compares.
   function automatic hue_split_type hue_split(input logic [HUE_W-1:0] hue);
      logic [HUE_W-1:0] h;
      logic [HUE_W-1:0] base;
      hue_split_type    res;
      h = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
      if (h >= 9'd300) begin
         res.sector = SEC_MAGENTA_RED;
         base = 9'd300;
      end else if (h >= 9'd240) begin
         res.sector = SEC_BLUE_MAGENTA;
         base = 9'd240;
      end else if (h >= 9'd180) begin
         res.sector = SEC_CYAN_BLUE;
         base = 9'd180;
      end else if (h >= 9'd120) begin
         res.sector = SEC_GREEN_CYAN;
         base = 9'd120;
      end else if (h >= HUE_SECTOR) begin
         res.sector = SEC_YELLOW_GREEN;
         base = HUE_SECTOR;
      end else begin
         res.sector = SEC_RED_YELLOW;
         base = 9'd0;
      end
      res.frac = FRAC_W'(h - base);
      return res;
   endfunction

endpackage

// File: hw/rtl/hsv2rgb_if.sv
// Valid/ready channel interfaces for HSV pixels in and RGB pixels out.
// Depends on hsv2rgb_pkg for field widths.
interface hsv2rgb_hsv_if
   import hsv2rgb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CH_W-1:0]   saturation;
   logic [CH_W-1:0]   brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if
   import hsv2rgb_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter, five-stage pipeline.
// Depends on hsv2rgb_pkg and the channel interfaces in hsv2rgb_if.sv.
//
//   channel    dir   fields                          transfer
//   req_chan   in    hue, saturation, brightness     valid && ready
//   rsp_chan   out   red, green, blue                valid && ready
//
// One pixel per clock while rsp_chan.ready is held high; each pixel passes
// from transfer to result through the stage chain hue split, first products,
// numerators and p, q and t by reciprocal multiply, sector mux.
// Reset is synchronous, active high, and clears the stage valid bits only.
// A stalled result holds in the output register; each stage keeps its item
// until the next stage takes it, and empty stages fill under a stall.
module hsv_to_rgb_converter
   import hsv2rgb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   hsv2rgb_hsv_if.sink          req_chan,
   hsv2rgb_rgb_if.source        rsp_chan
);

   // stage valid bits and advance enables, index 0 is stage 1
   logic [4:0] vld_ff, vld_in;
   logic [4:0] adv;

   // stage 1: hue split
   hue_split_type     split1_in;
   sector_type        sec1_ff;
   logic [FRAC_W-1:0] frac1_ff;
   logic [CH_W-1:0]   sat1_ff, val1_ff;

   // stage 2: first products
   logic [PROD_W-1:0] sf2_in, sg2_in, sf2_ff, sg2_ff;
   logic [PNUM_W-1:0] pn2_in, pn2_ff;
   sector_type        sec2_ff;
   logic [CH_W-1:0]   val2_ff;

   // stage 3: numerators and p
   logic [QNUM_W-1:0]  qn3_in, tn3_in, qn3_ff, tn3_ff;
   logic [PPROD_W-1:0] pprod;
   logic [CH_W-1:0]    p3_in, p3_ff;
   sector_type         sec3_ff;
   logic [CH_W-1:0]    val3_ff;

   // stage 4: q and t
   logic [QPROD_W-1:0] qprod, tprod;
   logic [CH_W-1:0]    q4_in, t4_in, q4_ff, t4_ff, p4_ff, val4_ff;
   sector_type         sec4_ff;

   // stage 5: output register
   logic [CH_W-1:0] red_in, green_in, blue_in;
   logic [CH_W-1:0] red_ff, green_ff, blue_ff, val5_ff;

   // advance chain, from the output back
   always_comb begin
      adv[4] = !vld_ff[4] || rsp_chan.ready;
      adv[3] = !vld_ff[3] || adv[4];
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
   end

   assign req_chan.ready = adv[0];

   // valid bits move with the data
   always_comb begin
      vld_in[0] = adv[0] ? req_chan.valid : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = adv[3] ? vld_ff[2] : vld_ff[3];
      vld_in[4] = adv[4] ? vld_ff[3] : vld_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: wrap hue, sector and fraction
   assign split1_in = hue_split(req_chan.hue);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sec1_ff  <= split1_in.sector;
         frac1_ff <= split1_in.frac;
         sat1_ff  <= req_chan.saturation;
         val1_ff  <= req_chan.brightness;
      end
   end

   // stage 2: s*f, s*(60-f), v*(255-s)
   always_comb begin
      sf2_in = PROD_W'(sat1_ff) * PROD_W'(frac1_ff);
      sg2_in = PROD_W'(sat1_ff) * PROD_W'(FRAC_FULL - frac1_ff);
      pn2_in = PNUM_W'(val1_ff) * PNUM_W'(CH_MAX - sat1_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sf2_ff  <= sf2_in;
         sg2_ff  <= sg2_in;
         pn2_ff  <= pn2_in;
         sec2_ff <= sec1_ff;
         val2_ff <= val1_ff;
      end
   end

   // stage 3: q and t numerators, p by reciprocal of 255
   always_comb begin
      qn3_in = QNUM_W'(val2_ff) * QNUM_W'(QT_DEN - sf2_ff);
      tn3_in = QNUM_W'(val2_ff) * QNUM_W'(QT_DEN - sg2_ff);
      pprod  = PPROD_W'(pn2_ff) * PPROD_W'(P_RECIP);
      p3_in  = pprod[P_SHIFT +: CH_W];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         qn3_ff  <= qn3_in;
         tn3_ff  <= tn3_in;
         p3_ff   <= p3_in;
         sec3_ff <= sec2_ff;
         val3_ff <= val2_ff;
      end
   end

   // stage 4: q and t by reciprocal of 15300
   always_comb begin
      qprod = QPROD_W'(qn3_ff) * QPROD_W'(QT_RECIP);
      tprod = QPROD_W'(tn3_ff) * QPROD_W'(QT_RECIP);
      q4_in = qprod[QT_SHIFT +: CH_W];
      t4_in = tprod[QT_SHIFT +: CH_W];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         q4_ff   <= q4_in;
         t4_ff   <= t4_in;
         p4_ff   <= p3_ff;
         sec4_ff <= sec3_ff;
         val4_ff <= val3_ff;
      end
   end

   // stage 5: place v, p, q, t on the channels by sector
   always_comb begin
      case (sec4_ff)
         SEC_RED_YELLOW: begin
            red_in = val4_ff; green_in = t4_ff;   blue_in = p4_ff;
         end
         SEC_YELLOW_GREEN: begin
            red_in = q4_ff;   green_in = val4_ff; blue_in = p4_ff;
         end
         SEC_GREEN_CYAN: begin
            red_in = p4_ff;   green_in = val4_ff; blue_in = t4_ff;
         end
         SEC_CYAN_BLUE: begin
            red_in = p4_ff;   green_in = q4_ff;   blue_in = val4_ff;
         end
         SEC_BLUE_MAGENTA: begin
            red_in = t4_ff;   green_in = p4_ff;   blue_in = val4_ff;
         end
         default: begin
            red_in = val4_ff; green_in = p4_ff;   blue_in = q4_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         val5_ff  <= val4_ff;
      end
   end

   assign rsp_chan.valid = vld_ff[4];
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

   // checks
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted pixel did not reach stage 1");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> frac1_ff < FRAC_FULL)
      else $error("hue fraction out of sector");

   a_max_is_value: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (red_ff == val5_ff || green_ff == val5_ff ||
                          blue_ff == val5_ff))
      else $error("no channel carries the brightness");

   a_below_value: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (red_ff <= val5_ff && green_ff <= val5_ff &&
                          blue_ff <= val5_ff))
      else $error("channel above brightness");

endmodule
